@@ rtl/core/esc_pkg.sv @@
// Shared types and constants for the EEPROM shadow cache sequencer.
// No dependencies; imported by the controller, datapath, top level and checker.
package esc_pkg;

    localparam int MAP_SIZE = 32;
    localparam int ADDR_W   = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
    localparam int IDX_W    = 5;
    localparam int BYTE_W   = 8;
    localparam int CMD_W    = 2;

    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(MAP_SIZE - 1);
    localparam logic [BYTE_W-1:0] PUB_DEFAULT = BYTE_W'(50);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_STAGE  = 2'd1,
        CMD_COMMIT = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_LOAD  = 2'd0,
        PH_READY = 2'd1,
        PH_WRITE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_READ = 2'd1,
        CS_EXEC = 2'd2,
        CS_OUT  = 2'd3
    } t_ctl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
    } t_ctl_cmd;

endpackage

@@ rtl/core/esc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module esc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/esc_ctrl.sv @@
// Sequencing state machine: request handshakes and datapath commands.
// Depends on esc_pkg.
module esc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output esc_pkg::t_ctl_cmd o_cmd
);
    import esc_pkg::*;

    t_ctl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        case (r_state)
            CS_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = CS_READ;
                end
            end
            CS_READ: begin
                n_state = CS_EXEC;
            end
            CS_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = CS_OUT;
            end
            CS_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/esc_dpath.sv @@
// Datapath: phase, address counter, the three byte stores and the result registers.
// Depends on esc_pkg and esc_ram.
module esc_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  esc_pkg::t_ctl_cmd          i_cmd,
    input  logic [esc_pkg::CMD_W-1:0]  i_command,
    input  logic                       i_eeprom_ready,
    input  logic [esc_pkg::BYTE_W-1:0] i_eeprom_rdata,
    input  logic [esc_pkg::IDX_W-1:0]  i_index,
    input  logic [esc_pkg::BYTE_W-1:0] i_value,
    output logic                       o_eeprom_write_en,
    output logic [esc_pkg::IDX_W-1:0]  o_eeprom_addr,
    output logic [esc_pkg::BYTE_W-1:0] o_eeprom_wdata,
    output logic                       o_accepted,
    output logic [esc_pkg::BYTE_W-1:0] o_read_data,
    output logic                       o_loaded,
    output logic                       o_busy_res,
    output logic [esc_pkg::IDX_W-1:0]  o_access_addr
);
    import esc_pkg::*;

    // Captured request.
    t_cmd              r_cmd;
    logic              r_rdy;
    logic [BYTE_W-1:0] r_rdata;
    logic [IDX_W-1:0]  r_index;
    logic [BYTE_W-1:0] r_value;

    // Architectural state.
    t_phase            r_phase, n_phase;
    logic [ADDR_W-1:0] r_counter, n_counter;
    logic              r_loaded, n_loaded;

    // Result registers.
    logic              r_wen, n_wen;
    logic [IDX_W-1:0]  r_waddr, n_waddr;
    logic [BYTE_W-1:0] r_wdata, n_wdata;
    logic              r_acc, n_acc;
    logic [BYTE_W-1:0] r_rd, n_rd;

    // Store ports.
    logic              cache_we, staged_we, pub_we;
    logic [BYTE_W-1:0] cache_wdata;
    logic [BYTE_W-1:0] cache_q, staged_q, pub_q;
    logic              idx_ok;
    logic [ADDR_W-1:0] idx_addr;

    assign idx_ok   = (32'(r_index) < MAP_SIZE);
    assign idx_addr = ADDR_W'(r_index);

    // The published store is written alongside the cache during the load, so it
    // holds the loaded map once the load completes; before that it reads as 50.
    esc_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_SIZE)) u_cache (
        .i_clk   (i_clk),
        .i_we    (cache_we),
        .i_waddr (r_counter),
        .i_wdata (cache_wdata),
        .i_raddr (r_counter),
        .o_rdata (cache_q)
    );

    esc_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_SIZE)) u_staged (
        .i_clk   (i_clk),
        .i_we    (staged_we),
        .i_waddr (idx_addr),
        .i_wdata (r_value),
        .i_raddr (r_counter),
        .o_rdata (staged_q)
    );

    esc_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_SIZE)) u_pub (
        .i_clk   (i_clk),
        .i_we    (pub_we),
        .i_waddr (r_counter),
        .i_wdata (r_rdata),
        .i_raddr (idx_addr),
        .o_rdata (pub_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd   <= t_cmd'(i_command);
            r_rdy   <= i_eeprom_ready;
            r_rdata <= i_eeprom_rdata;
            r_index <= i_index;
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_wen   <= n_wen;
            r_waddr <= n_waddr;
            r_wdata <= n_wdata;
            r_acc   <= n_acc;
            r_rd    <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LOAD;
            r_counter <= '0;
            r_loaded  <= 1'b0;
        end else if (i_cmd.exec) begin
            r_phase   <= n_phase;
            r_counter <= n_counter;
            r_loaded  <= n_loaded;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_counter   = r_counter;
        n_loaded    = r_loaded;
        n_wen       = 1'b0;
        n_waddr     = '0;
        n_wdata     = '0;
        n_acc       = 1'b0;
        n_rd        = '0;
        cache_we    = 1'b0;
        cache_wdata = r_rdata;
        staged_we   = 1'b0;
        pub_we      = 1'b0;
        case (r_cmd)
            CMD_TICK: begin
                if (r_rdy && r_phase == PH_LOAD) begin
                    cache_we = i_cmd.exec;
                    pub_we   = i_cmd.exec;
                    if (r_counter == LAST_ADDR) begin
                        n_loaded = 1'b1;
                        n_phase  = PH_READY;
                    end else begin
                        n_counter = r_counter + ADDR_W'(1);
                    end
                end else if (r_rdy && r_phase == PH_WRITE) begin
                    if (staged_q != cache_q) begin
                        n_wen       = 1'b1;
                        n_waddr     = IDX_W'(r_counter);
                        n_wdata     = staged_q;
                        cache_we    = i_cmd.exec;
                        cache_wdata = staged_q;
                    end
                    if (r_counter == LAST_ADDR) begin
                        n_counter = '0;
                        n_phase   = PH_READY;
                    end else begin
                        n_counter = r_counter + ADDR_W'(1);
                    end
                end
            end
            CMD_STAGE: begin
                staged_we = i_cmd.exec && (r_phase == PH_READY) && idx_ok;
            end
            CMD_COMMIT: begin
                if (r_phase == PH_READY) begin
                    n_phase   = PH_WRITE;
                    n_counter = '0;
                    n_acc     = 1'b1;
                end
            end
            CMD_READ: begin
                if (idx_ok) begin
                    n_rd = r_loaded ? pub_q : PUB_DEFAULT;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    assign o_eeprom_write_en = r_wen;
    assign o_eeprom_addr     = r_waddr;
    assign o_eeprom_wdata    = r_wdata;
    assign o_accepted        = r_acc;
    assign o_read_data       = r_rd;
    assign o_loaded          = r_loaded;
    assign o_busy_res        = (r_phase != PH_READY);
    assign o_access_addr     = IDX_W'(r_counter);

endmodule

@@ rtl/core/eeprom_shadow_cache_sequencer.sv @@
// EEPROM shadow cache sequencer top level: controller plus datapath.
// Depends on esc_pkg, esc_ctrl, esc_dpath and esc_ram.
// A request accepted in the idle state passes through the store-read and execute
// states; its result is registered in execute and offered in the output state.
// A new request is taken only once the last result has been taken; the registered
// read of the byte stores sets the extra store-read state.
// Reset (synchronous, active low) enters the load phase with the counter at zero,
// the loaded flag clear and published values reading 50; no clearing pass is run.
module eeprom_shadow_cache_sequencer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [esc_pkg::CMD_W-1:0]  i_command,
    input  logic                       i_eeprom_ready,
    input  logic [esc_pkg::BYTE_W-1:0] i_eeprom_rdata,
    input  logic [esc_pkg::IDX_W-1:0]  i_index,
    input  logic [esc_pkg::BYTE_W-1:0] i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_eeprom_write_en,
    output logic [esc_pkg::IDX_W-1:0]  o_eeprom_addr,
    output logic [esc_pkg::BYTE_W-1:0] o_eeprom_wdata,
    output logic                       o_accepted,
    output logic [esc_pkg::BYTE_W-1:0] o_read_data,
    output logic                       o_loaded,
    output logic                       o_busy_res,
    output logic [esc_pkg::IDX_W-1:0]  o_access_addr
);
    import esc_pkg::*;

    // The controller walks each request through capture, store read, execute
    // and result hand-off. It only issues commands; all architectural state lives in the
    // datapath.
    t_ctl_cmd ctl_cmd;

    esc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (ctl_cmd)
    );

    // The datapath holds the phase, the address counter, the shadow cache, the
    // staged bytes and the published values. Published values are filled during
    // the load together with the cache and are masked to 50 until the load ends,
    // which gives the end-of-load copy without a separate sweep.
    esc_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (ctl_cmd),
        .i_command         (i_command),
        .i_eeprom_ready    (i_eeprom_ready),
        .i_eeprom_rdata    (i_eeprom_rdata),
        .i_index           (i_index),
        .i_value           (i_value),
        .o_eeprom_write_en (o_eeprom_write_en),
        .o_eeprom_addr     (o_eeprom_addr),
        .o_eeprom_wdata    (o_eeprom_wdata),
        .o_accepted        (o_accepted),
        .o_read_data       (o_read_data),
        .o_loaded          (o_loaded),
        .o_busy_res        (o_busy_res),
        .o_access_addr     (o_access_addr)
    );

endmodule

@@ rtl/core/esc_checker.sv @@
// Port-level checks for the EEPROM shadow cache sequencer, bound to the top level.
// Depends on esc_pkg and eeprom_shadow_cache_sequencer.
module esc_assertions (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_eeprom_write_en,
    input logic [esc_pkg::IDX_W-1:0]  o_eeprom_addr,
    input logic [esc_pkg::BYTE_W-1:0] o_eeprom_wdata,
    input logic                       o_accepted,
    input logic                       o_loaded,
    input logic                       o_busy_res,
    input logic [esc_pkg::IDX_W-1:0]  o_access_addr
);
    import esc_pkg::*;

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // No new request is taken while a result is pending.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("request taken with a result pending");

    // An accepted commit starts the write phase at address zero.
    a_commit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> o_busy_res && o_access_addr == '0
            && !o_eeprom_write_en)
        else $error("commit did not start the write phase");

    // Address and data of the EEPROM port are zero when nothing is written.
    a_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_eeprom_write_en |-> o_eeprom_addr == '0
            && o_eeprom_wdata == '0)
        else $error("write fields set without a write");

    // Once loaded, the block stays loaded until reset; before that it is busy.
    a_loaded_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_loaded || !o_busy_res) |=> o_loaded)
        else $error("loaded flag dropped");

endmodule

bind eeprom_shadow_cache_sequencer esc_assertions u_esc_assertions (.*);
